@@ rtl/i2cee_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM master package
// Shared types, register codes and reset values for the I2C EEPROM master.
// ----------------------------------------------------------------------------
package i2cee_pkg;

	// default write buffer depth
	localparam int MAX_BYTES_DEF = 16;

	// configuration register reset values
	localparam logic [6:0]  DEV_ADDR_RST = 7'h50;
	localparam logic [15:0] PHASE_RST    = 16'd1;
	localparam logic [15:0] SS_RST       = 16'd10;
	localparam logic [3:0]  POLLS_RST    = 4'd5;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_DEV_ADDR = 2'd0,
		CFG_PHASE    = 2'd1,
		CFG_SS       = 2'd2,
		CFG_POLLS    = 2'd3
	} cfg_idx_t;

	// request codes
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	// bit sequencer steps
	typedef enum logic [4:0] {
		ST_IDLE      = 5'd0,
		ST_START_A   = 5'd1,
		ST_START_B   = 5'd2,
		ST_BIT_LOW   = 5'd3,
		ST_BIT_DATA  = 5'd4,
		ST_BIT_HIGH  = 5'd5,
		ST_ACK_LOW   = 5'd6,
		ST_ACK_HIGH  = 5'd7,
		ST_ACK_POLL  = 5'd8,
		ST_RX_LOW    = 5'd9,
		ST_RX_HIGH   = 5'd10,
		ST_RX_END    = 5'd11,
		ST_MACK_DATA = 5'd12,
		ST_MACK_HIGH = 5'd13,
		ST_MACK_LOW  = 5'd14,
		ST_STOP_A    = 5'd15,
		ST_STOP_B    = 5'd16,
		ST_STOP_TAIL = 5'd17
	} step_t;

	// role of the byte on the wire
	typedef enum logic [1:0] {
		ROLE_DEVW = 2'd0,
		ROLE_WORD = 2'd1,
		ROLE_DATA = 2'd2,
		ROLE_DEVR = 2'd3
	} role_t;

	// configuration register set
	typedef struct packed {
		logic [6:0]  dev_addr;
		logic [15:0] phase_ticks;
		logic [15:0] ss_ticks;
		logic [3:0]  ack_polls;
	} cfg_t;

	// one result word
	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_oe;
		logic       busy;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       rx_last;
		logic       done;
		logic       ack_error;
	} res_t;

endpackage

@@ rtl/i2c_eeprom_master_core.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM master core
// Bit-level I2C master for serial EEPROM byte writes and sequential reads.
// ----------------------------------------------------------------------------
// Every accepted input word is one tick of the bit sequencer: the block takes
// one word per clock and returns exactly one result word for it, in the next
// cycle, from an output register. The input side stalls only while that
// register holds a result that the output side is stalling. Line levels for
// SCL and SDA, the SDA output enable and the status flags in each result are
// those after the tick. Write data bytes are loaded ahead of a write request
// into a buffer of MAX_BYTES entries; configuration writes are taken at any
// time (cfg_ready is always high) and apply from the next bit phase.
module i2c_eeprom_master_core import i2cee_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic        sda_in,
	input  logic [7:0]  word_addr,
	input  logic [4:0]  byte_count,
	input  logic [7:0]  write_byte,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl,
	output logic        sda_out,
	output logic        sda_oe,
	output logic        busy_res,
	output logic        rx_valid,
	output logic [7:0]  rx_data,
	output logic        rx_last,
	output logic        done_res,
	output logic        ack_error,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CW = $clog2(MAX_BYTES + 1);

	cfg_t          cfg_q;
	res_t          res, res_q;
	logic          out_valid_q;
	logic          adv;
	logic          buf_wr_en;
	logic [AW-1:0] buf_wr_addr, buf_rd_addr;
	logic [7:0]    buf_wr_data, buf_rd_data;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign adv       = in_valid && !in_stall;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr    <= DEV_ADDR_RST;
			cfg_q.phase_ticks <= PHASE_RST;
			cfg_q.ss_ticks    <= SS_RST;
			cfg_q.ack_polls   <= POLLS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEV_ADDR: cfg_q.dev_addr    <= cfg_data[6:0];
				CFG_PHASE:    cfg_q.phase_ticks <= cfg_data;
				CFG_SS:       cfg_q.ss_ticks    <= cfg_data;
				CFG_POLLS:    cfg_q.ack_polls   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	i2cee_wbuf #(
		.MAX_BYTES (MAX_BYTES),
		.AW        (AW)
	) u_wbuf (
		.clk     (clk),
		.wr_en   (buf_wr_en && adv),
		.wr_addr (buf_wr_addr),
		.wr_data (buf_wr_data),
		.rd_addr (buf_rd_addr),
		.rd_data (buf_rd_data)
	);

	i2cee_seq #(
		.MAX_BYTES (MAX_BYTES),
		.AW        (AW),
		.CW        (CW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cfg         (cfg_q),
		.req_type    (req_type),
		.sda_in      (sda_in),
		.word_addr   (word_addr),
		.byte_count  (byte_count),
		.write_byte  (write_byte),
		.buf_rd_data (buf_rd_data),
		.buf_wr_en   (buf_wr_en),
		.buf_wr_addr (buf_wr_addr),
		.buf_wr_data (buf_wr_data),
		.buf_rd_addr (buf_rd_addr),
		.res         (res)
	);

	// output register: load on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign scl       = res_q.scl;
	assign sda_out   = res_q.sda_out;
	assign sda_oe    = res_q.sda_oe;
	assign busy_res  = res_q.busy;
	assign rx_valid  = res_q.rx_valid;
	assign rx_data   = res_q.rx_data;
	assign rx_last   = res_q.rx_last;
	assign done_res  = res_q.done;
	assign ack_error = res_q.ack_error;

endmodule

@@ rtl/i2cee_wbuf.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM master write buffer
// Data byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2cee_wbuf import i2cee_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF,
	parameter int AW        = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [MAX_BYTES];
	logic [7:0] rd_data_q;

	// write loaded bytes
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// prefetch the entry at the transfer index
	always_ff @(posedge clk) begin
		if (32'(rd_addr) < MAX_BYTES) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/i2cee_seq.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM master bit sequencer
// Sequencer state and one tick of next-state logic per accepted word.
// ----------------------------------------------------------------------------
module i2cee_seq import i2cee_pkg::*; #(
	parameter int MAX_BYTES = MAX_BYTES_DEF,
	parameter int AW        = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
	parameter int CW        = $clog2(MAX_BYTES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  cfg_t          cfg,
	input  logic [1:0]    req_type,
	input  logic          sda_in,
	input  logic [7:0]    word_addr,
	input  logic [4:0]    byte_count,
	input  logic [7:0]    write_byte,
	input  logic [7:0]    buf_rd_data,
	output logic          buf_wr_en,
	output logic [AW-1:0] buf_wr_addr,
	output logic [7:0]    buf_wr_data,
	output logic [AW-1:0] buf_rd_addr,
	output res_t          res
);

	step_t         step_q, n_step, go_step;
	role_t         role_q, n_role;
	logic [3:0]    bit_q, n_bit;
	logic [CW-1:0] bytes_q, n_bytes;
	logic [CW-1:0] fill_q, n_fill;
	logic [CW-1:0] xfer_q, n_xfer;
	logic [7:0]    shift_q, n_shift;
	logic [15:0]   delay_q, n_delay, dly;
	logic [3:0]    poll_q, n_poll, poll_base, poll_dec;
	logic          read_q, n_read;
	logic [7:0]    target_q, n_target;
	logic          scl_q, n_scl, sda_q, n_sda, drive_q, n_drive, err_q, n_err;
	logic          go, poll_do, next_data;
	logic [15:0]   ph, ss;

	assign ph          = (cfg.phase_ticks == '0) ? 16'd1 : cfg.phase_ticks;
	assign ss          = (cfg.ss_ticks == '0) ? 16'd1 : cfg.ss_ticks;
	assign buf_wr_addr = fill_q[AW-1:0];
	assign buf_wr_data = write_byte;
	assign buf_rd_addr = xfer_q[AW-1:0];

	// next state and result for one tick
	always_comb begin
		n_step = step_q; n_role = role_q; n_bit = bit_q; n_bytes = bytes_q;
		n_fill = fill_q; n_xfer = xfer_q; n_shift = shift_q; n_delay = delay_q;
		n_poll = poll_q; n_read = read_q; n_target = target_q; n_scl = scl_q;
		n_sda = sda_q; n_drive = drive_q; n_err = err_q;
		go = 1'b0; go_step = ST_IDLE; poll_do = 1'b0; poll_base = poll_q;
		poll_dec = '0; next_data = 1'b0; buf_wr_en = 1'b0;
		res = '0;
		dly = (delay_q != '0) ? delay_q - 16'd1 : 16'd0;

		if (step_q == ST_IDLE) begin
			// load a byte or open a transaction
			if (req_type == REQ_LOAD) begin
				if (32'(fill_q) < MAX_BYTES) begin
					buf_wr_en = 1'b1;
					n_fill    = fill_q + 1'b1;
				end
			end else if (req_type == REQ_WRITE || req_type == REQ_READ) begin
				n_read   = (req_type == REQ_READ);
				n_target = word_addr;
				n_bytes  = (32'(byte_count) > MAX_BYTES) ? CW'(MAX_BYTES) : CW'(byte_count);
				n_xfer   = '0;
				n_err    = 1'b0;
				n_role   = ROLE_DEVW;
				if (req_type == REQ_WRITE) begin
					n_fill = '0;
				end
				go = 1'b1; go_step = ST_START_A;
			end
		end else if (step_q == ST_ACK_POLL) begin
			poll_do = 1'b1;
		end else begin
			// count down the phase, act on expiry
			n_delay = dly;
			if (dly == '0) begin
				case (step_q)
					ST_START_A: begin go = 1'b1; go_step = ST_START_B; end
					ST_START_B: begin
						n_shift = {cfg.dev_addr, role_q == ROLE_DEVR};
						n_bit   = '0;
						go = 1'b1; go_step = ST_BIT_LOW;
					end
					ST_BIT_LOW:  begin go = 1'b1; go_step = ST_BIT_DATA; end
					ST_BIT_DATA: begin go = 1'b1; go_step = ST_BIT_HIGH; end
					ST_BIT_HIGH: begin
						n_shift = {shift_q[6:0], 1'b0};
						n_bit   = bit_q + 4'd1;
						go = 1'b1;
						go_step = (n_bit >= 4'd8) ? ST_ACK_LOW : ST_BIT_LOW;
					end
					ST_ACK_LOW: begin go = 1'b1; go_step = ST_ACK_HIGH; end
					ST_ACK_HIGH: begin
						n_step    = ST_ACK_POLL;
						poll_do   = 1'b1;
						poll_base = (cfg.ack_polls == '0) ? 4'd1 : cfg.ack_polls;
					end
					ST_RX_LOW: begin go = 1'b1; go_step = ST_RX_HIGH; end
					ST_RX_HIGH: begin
						n_shift = {shift_q[6:0], sda_in};
						n_bit   = bit_q + 4'd1;
						go = 1'b1;
						if (n_bit >= 4'd8) begin
							res.rx_valid = 1'b1;
							res.rx_data  = n_shift;
							res.rx_last  = (bytes_q <= CW'(1));
							if (bytes_q != '0) begin
								n_bytes = bytes_q - 1'b1;
							end
							go_step = ST_RX_END;
						end else begin
							go_step = ST_RX_LOW;
						end
					end
					ST_RX_END:    begin go = 1'b1; go_step = ST_MACK_DATA; end
					ST_MACK_DATA: begin go = 1'b1; go_step = ST_MACK_HIGH; end
					ST_MACK_HIGH: begin go = 1'b1; go_step = ST_MACK_LOW; end
					ST_MACK_LOW: begin
						go = 1'b1;
						if (bytes_q != '0) begin
							n_bit = '0; n_shift = '0; go_step = ST_RX_LOW;
						end else begin
							go_step = ST_STOP_A;
						end
					end
					ST_STOP_A: begin go = 1'b1; go_step = ST_STOP_B; end
					ST_STOP_B: begin
						n_sda = 1'b1;
						if (err_q) begin
							n_step = ST_IDLE; n_delay = '0;
							res.done = 1'b1; res.ack_error = err_q;
						end else begin
							go = 1'b1; go_step = ST_STOP_TAIL;
						end
					end
					default: begin
						n_step = ST_IDLE; n_delay = '0;
						res.done = 1'b1; res.ack_error = err_q;
					end
				endcase
			end
		end

		// sample the ACK slot
		if (poll_do) begin
			if (!sda_in) begin
				n_drive = 1'b1;
				n_scl   = 1'b0;
				go      = 1'b1;
				case (role_q)
					ROLE_DEVW: begin
						n_role = ROLE_WORD; n_shift = target_q; n_bit = '0;
						go_step = ST_BIT_LOW;
					end
					ROLE_WORD: begin
						if (read_q) begin
							n_role = ROLE_DEVR; go_step = ST_START_A;
						end else begin
							next_data = 1'b1;
						end
					end
					ROLE_DATA: next_data = 1'b1;
					default: begin
						if (bytes_q != '0) begin
							n_bit = '0; n_shift = '0; go_step = ST_RX_LOW;
						end else begin
							go_step = ST_STOP_A;
						end
					end
				endcase
			end else begin
				poll_dec = poll_base - 4'd1;
				n_poll   = poll_dec;
				if (poll_dec == '0) begin
					n_err = 1'b1; go = 1'b1; go_step = ST_STOP_A;
				end
			end
		end

		// send the next buffered byte or stop
		if (next_data) begin
			if (bytes_q != '0) begin
				n_bytes = bytes_q - 1'b1;
				n_xfer  = xfer_q + 1'b1;
				n_role  = ROLE_DATA;
				n_shift = buf_rd_data;
				n_bit   = '0;
				go_step = ST_BIT_LOW;
			end else begin
				go_step = ST_STOP_A;
			end
		end

		// enter the new phase: line levels and delay
		if (go) begin
			n_step  = go_step;
			n_delay = ph;
			case (go_step)
				ST_START_A: begin
					n_scl = 1'b1; n_sda = 1'b1; n_drive = 1'b1; n_delay = ss;
				end
				ST_START_B:   begin n_sda = 1'b0; n_delay = ss; end
				ST_BIT_LOW:   begin n_scl = 1'b0; n_drive = 1'b1; end
				ST_BIT_DATA:  n_sda = n_shift[7];
				ST_BIT_HIGH:  n_scl = 1'b1;
				ST_ACK_LOW:   begin n_scl = 1'b0; n_drive = 1'b0; end
				ST_ACK_HIGH:  n_scl = 1'b1;
				ST_RX_LOW:    begin n_scl = 1'b0; n_drive = 1'b0; end
				ST_RX_HIGH:   n_scl = 1'b1;
				ST_RX_END:    n_scl = 1'b0;
				ST_MACK_DATA: begin n_drive = 1'b1; n_sda = (n_bytes == '0); end
				ST_MACK_HIGH: n_scl = 1'b1;
				ST_MACK_LOW:  n_scl = 1'b0;
				ST_STOP_A: begin
					n_scl = 1'b0; n_sda = 1'b0; n_drive = 1'b1; n_delay = ss;
				end
				ST_STOP_B:    begin n_scl = 1'b1; n_delay = ss; end
				default: ;
			endcase
		end

		res.scl     = n_scl;
		res.sda_out = n_sda;
		res.sda_oe  = n_drive;
		res.busy    = (n_step != ST_IDLE);
	end

	// advance the sequencer on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE; role_q <= ROLE_DEVW; bit_q <= '0; bytes_q <= '0;
			fill_q <= '0; xfer_q <= '0; shift_q <= '0; delay_q <= '0;
			poll_q <= '0; read_q <= 1'b0; target_q <= '0; scl_q <= 1'b1;
			sda_q <= 1'b1; drive_q <= 1'b1; err_q <= 1'b0;
		end else if (adv) begin
			step_q <= n_step; role_q <= n_role; bit_q <= n_bit; bytes_q <= n_bytes;
			fill_q <= n_fill; xfer_q <= n_xfer; shift_q <= n_shift; delay_q <= n_delay;
			poll_q <= n_poll; read_q <= n_read; target_q <= n_target; scl_q <= n_scl;
			sda_q <= n_sda; drive_q <= n_drive; err_q <= n_err;
		end
	end

endmodule

@@ rtl/i2cee_chk.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM master checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
module i2cee_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl,
	input logic       sda_oe,
	input logic       busy_res,
	input logic       rx_valid,
	input logic [7:0] rx_data,
	input logic       rx_last,
	input logic       done_res,
	input logic       ack_error
);

	// input side stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// a transaction ends idle, error flag only with the end pulse
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (done_res || ack_error) |-> done_res && !busy_res)
		else $error("end pulse or error outside transaction end");

	// a received byte is shown with SDA released and the bus busy
	a_rx_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (rx_valid || rx_last) |-> rx_valid && !sda_oe && busy_res
		&& !scl)
		else $error("received byte with SDA driven or bus idle");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rx_data) && $stable(done_res))
		else $error("stalled result changed");

endmodule

bind i2c_eeprom_master_core i2cee_chk u_i2cee_chk (.*);
